// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AST_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define AST_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/epct_pkg.sv =====
// Shared constants and the arctangent table for the edge point continuity test
`timescale 1ns / 1ps

package epct_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int PRESCALE     = 24;
  // datapath width of the rotation stages: |x|,|y| stay below 2^42
  localparam int CW           = 46;
  // latency of the angle unit: setup, rotations, rounding
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

  // configuration register indexes
  localparam logic REG_DIST  = 1'b0;
  localparam logic REG_ANGLE = 1'b1;

  localparam logic [15:0] DIST_THR_RST  = 16'd32;
  localparam logic [15:0] ANGLE_THR_RST = 16'd2731;

  // atan(2^-i), 2^32 units per turn
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/edge_point_continuity_test.sv =====
// Top level of the edge point continuity test
//
// channel | dir | handshake          | beat
// in      | in  | in_valid/in_stall  | a reference and a new edge point, and to_back
// out     | out | out_valid/out_stall| continuous flag
// cfg     | in  | cfg_valid/cfg_ready| register index and data
//
// One beat accepted per cycle while the output beat is not stalled; the flag is presented
// after its input beat passes the input register, CORDIC angle pipelines and output register.
// The three angle units set the depth.
// The whole pipeline holds while the output beat is stalled.
// Synchronous reset clears valid bits and loads threshold defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module edge_point_continuity_test #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [15:0] ref_x,
  input  logic        [15:0] ref_y,
  input  logic signed [15:0] ref_gx,
  input  logic signed [15:0] ref_gy,
  input  logic        [15:0] new_x,
  input  logic        [15:0] new_y,
  input  logic signed [15:0] new_gx,
  input  logic signed [15:0] new_gy,
  input  logic               to_back,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               continuous,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic        [15:0] cfg_data
);

  localparam int CL = epct_pkg::CORDIC_LAT;
  localparam logic [ANGLE_BITS:0] HALF = (ANGLE_BITS+1)'(1) << (ANGLE_BITS-1);
  localparam logic [ANGLE_BITS:0] FULL = (ANGLE_BITS+1)'(1) << ANGLE_BITS;

  logic [15:0] dist_thr;
  logic [15:0] angle_thr;

  // config registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_thr  <= epct_pkg::DIST_THR_RST;
      angle_thr <= epct_pkg::ANGLE_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == epct_pkg::REG_DIST) dist_thr <= cfg_data;
      else                                 angle_thr <= cfg_data;
    end
  end

  // global advance
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // input register
  logic signed [16:0] dx, dy, rgx, rgy, ngx, ngy;
  logic [CL:0]        v;
  logic [CL:0]        tb;
  always_ff @(posedge clk) begin
    if (en) begin
      dx  <= 17'($signed({1'b0, new_x}) - $signed({1'b0, ref_x}));
      dy  <= 17'($signed({1'b0, new_y}) - $signed({1'b0, ref_y}));
      rgx <= {ref_gx[15], ref_gx};
      rgy <= {ref_gy[15], ref_gy};
      ngx <= {new_gx[15], new_gx};
      ngy <= {new_gy[15], new_gy};
      tb  <= {tb[CL-1:0], to_back};
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[CL-1:0], in_valid};
    end
  end

  // distance: square, sum, compare, then delay
  logic [33:0] sqx, sqy, dsum, thr_sq;
  logic [CL:3] dok;
  always_ff @(posedge clk) begin
    if (en) begin
      sqx    <= $unsigned(34'(dx) * 34'(dx));
      sqy    <= $unsigned(34'(dy) * 34'(dy));
      dsum   <= sqx + sqy;
      thr_sq <= 34'(dist_thr) * 34'(dist_thr);
      dok    <= {dok[CL-1:3], dsum <= thr_sq};
    end
  end

  // angle units
  logic [ANGLE_BITS-1:0] ang_ref, ang_new, ang_side;
  epct_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_ref (
    .clk(clk), .en(en), .x(rgx), .y(rgy), .angle(ang_ref));
  epct_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_new (
    .clk(clk), .en(en), .x(ngx), .y(ngy), .angle(ang_new));
  epct_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_side (
    .clk(clk), .en(en), .x(dx), .y(dy), .angle(ang_side));

  // final decision
  logic [ANGLE_BITS-1:0] dg, ds;
  logic [ANGLE_BITS:0]   mag;
  logic                  ang_ok, side_ok, pos;
  always_comb begin
    dg  = ang_new - ang_ref;
    ds  = ang_side - ang_ref;
    mag = ({1'b0, dg} <= HALF) ? {1'b0, dg} : FULL - {1'b0, dg};
    ang_ok = {mag, 16'b0} <= (ANGLE_BITS+17)'({angle_thr, {ANGLE_BITS{1'b0}}});
    pos = {1'b0, ds} <= HALF;
    side_ok = (ds == '0) || (tb[CL] ? !pos : pos);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[CL];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      continuous <= dok[CL] && ang_ok && side_ok;
    end
  end

  // checks
  `AST_NEXT(a_in_enters, clk, rst, in_valid && !in_stall, v[0], "accepted beat lost at entry")
  `AST_NEXT(a_out_loads, clk, rst, v[CL] && en, out_valid, "finished beat not presented")
  `AST_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(continuous) && $stable(v), "pipeline moved while stalled")

endmodule

// ===== hw/rtl/epct_cordic.sv =====
// Pipelined CORDIC vectoring unit: vector to binary angle, one stage per rotation
`timescale 1ns / 1ps

module epct_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [16:0]           x,
  input  logic signed [16:0]           y,
  output logic        [ANGLE_BITS-1:0] angle
);

  localparam int N  = epct_pkg::CORDIC_STEPS;
  localparam int CW = epct_pkg::CW;

  logic signed [CW-1:0] xs [0:N];
  logic signed [CW-1:0] ys [0:N];
  logic        [31:0]   acc [0:N];
  logic                 zero [0:N];

  // setup: fold left half-plane, prescale
  logic signed [17:0] xf;
  logic signed [17:0] yf;
  always_comb begin
    if (x < 0) begin
      xf = -{x[16], x};
      yf = -{y[16], y};
    end else begin
      xf = {x[16], x};
      yf = {y[16], y};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]   <= {{(CW-18-epct_pkg::PRESCALE){xf[17]}}, xf, {epct_pkg::PRESCALE{1'b0}}};
      ys[0]   <= {{(CW-18-epct_pkg::PRESCALE){yf[17]}}, yf, {epct_pkg::PRESCALE{1'b0}}};
      acc[0]  <= (x < 0) ? 32'h80000000 : 32'h0;
      zero[0] <= (x == 17'sd0) && (y == 17'sd0);
    end
  end

  // rotation stages
  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (ys[i] > 0) begin
          xs[i+1]  <= xs[i] + (ys[i] >>> i);
          ys[i+1]  <= ys[i] - (xs[i] >>> i);
          acc[i+1] <= acc[i] + epct_pkg::atan_val(5'(i));
        end else begin
          xs[i+1]  <= xs[i] - (ys[i] >>> i);
          ys[i+1]  <= ys[i] + (xs[i] >>> i);
          acc[i+1] <= acc[i] - epct_pkg::atan_val(5'(i));
        end
      end
    end
  end

  // round to ANGLE_BITS
  logic [31:0] acc_rnd;
  assign acc_rnd = acc[N] + (32'd1 << (31 - ANGLE_BITS));

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zero[N] ? '0 : acc_rnd[31 -: ANGLE_BITS];
    end
  end

endmodule

// ===== test/edge_point_continuity_test_tb.sv =====
// Self-checking testbench for the edge point continuity test block
`timescale 1ns / 1ps

module edge_point_continuity_test_tb;

  typedef struct {
    logic [15:0]        rx, ry, nx, ny;
    logic signed [15:0] rgx, rgy, ngx, ngy;
    logic               back;
  } pair_t;

  // Continuity predictor and the queue of flags still owed by the block
  class continuity_board;
    logic [15:0] dist_thr = epct_pkg::DIST_THR_RST;
    logic [15:0] ang_thr  = epct_pkg::ANGLE_THR_RST;
    bit          flags_due[$];
    int          beats_in, beats_out, passes;
    logic [31:0] arctan[28] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005};

    // binary angle of a vector by vectoring rotations
    function logic [15:0] heading(longint x, longint y);
      logic [31:0] acc;
      longint      xs, ys;
      acc = 0;
      if (x == 0 && y == 0) return 16'd0;
      if (x < 0) begin
        x = -x;
        y = -y;
        acc = 32'h80000000;
      end
      x = x <<< 24;
      y = y <<< 24;
      for (int i = 0; i < 28; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          acc = acc + arctan[i];
        end else begin
          x = x - ys;
          y = y + xs;
          acc = acc - arctan[i];
        end
      end
      acc = acc + 32'h00008000;
      return acc[31:16];
    endfunction

    function void note_pair(pair_t p);
      longint      dx, dy;
      logic [15:0] ra, d, mag, s;
      bit          ok;
      dx = longint'(p.nx) - longint'(p.rx);
      dy = longint'(p.ny) - longint'(p.ry);
      ok = 1;
      if (dx * dx + dy * dy > longint'(dist_thr) * longint'(dist_thr)) ok = 0;
      ra  = heading(p.rgx, p.rgy);
      d   = heading(p.ngx, p.ngy) - ra;
      mag = (d <= 16'h8000) ? d : 16'h0 - d;
      if (mag > ang_thr) ok = 0;
      s = heading(dx, dy) - ra;
      if (s != 0) begin
        if (p.back && s <= 16'h8000) ok = 0;
        if (!p.back && s > 16'h8000) ok = 0;
      end
      flags_due.push_back(ok);
      beats_in++;
    endfunction

    // returns an empty string when the flag matches
    function string check_flag(logic got);
      bit want;
      beats_out++;
      if (flags_due.size() == 0) return "result beat with nothing expected";
      want = flags_due.pop_front();
      passes += want;
      if (got !== want) return $sformatf("continuous %b, expected %b", got, want);
      return "";
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic        [15:0] ref_x = 0, ref_y = 0, new_x = 0, new_y = 0;
  logic signed [15:0] ref_gx = 0, ref_gy = 0, new_gx = 0, new_gy = 0;
  logic               to_back = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic               continuous;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic               cfg_index = epct_pkg::REG_DIST;
  logic        [15:0] cfg_data = 0;

  continuity_board board = new();
  int  errors = 0;
  int  stall_left = 0;
  bit  stall_on = 0;
  bit  quiet = 0;

  edge_point_continuity_test dut (.*);

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("timeout with %0d flags outstanding", board.flags_due.size());
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report(string msg);
    errors++;
    if (errors <= 40) $display("%0t: %s", $time, msg);
  endtask

  // accepted beats on both sides
  always @(posedge clk) begin
    string msg;
    if (!rst && in_valid && !in_stall) board.note_pair(pair_t'{
      rx: ref_x, ry: ref_y, nx: new_x, ny: new_y, rgx: ref_gx, rgy: ref_gy,
      ngx: new_gx, ngy: new_gy, back: to_back});
    if (!rst && out_valid && !out_stall) begin
      msg = board.check_flag(continuous);
      if (msg != "") report(msg);
    end
  end

  // receiver stall: short and long bursts, with quiet stretches
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 0;
    end else if (stall_left == 0) begin
      stall_on   = ($urandom_range(0, 9) < 4);
      stall_left = (stall_on && $urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                           : $urandom_range(1, 12);
      out_stall <= stall_on;
    end else begin
      stall_left--;
      out_stall <= stall_on;
    end
  end

  task automatic send(pair_t p);
    int gap;
    ref_x <= p.rx; ref_y <= p.ry; new_x <= p.nx; new_y <= p.ny;
    ref_gx <= p.rgx; ref_gy <= p.rgy; new_gx <= p.ngx; new_gy <= p.ngy;
    to_back <= p.back;
    in_valid <= 1;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    gap = ($urandom_range(0, 2) != 0) ? 0 :
          ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every expected flag has come back
  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (board.flags_due.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
    if (idx == epct_pkg::REG_DIST) board.dist_thr = val;
    else board.ang_thr = val;
  endtask

  function automatic logic [15:0] nudge(logic [15:0] v, int span);
    return v + 16'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // mostly nearby pairs with similar gradients, some fully random
  function automatic pair_t random_pair();
    pair_t p;
    int    span;
    p.rx = 16'($urandom); p.ry = 16'($urandom);
    p.rgx = 16'($urandom); p.rgy = 16'($urandom);
    p.back = 1'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      p.nx = 16'($urandom); p.ny = 16'($urandom);
      p.ngx = 16'($urandom); p.ngy = 16'($urandom);
    end else begin
      span = ($urandom_range(0, 3) == 0) ? 2000 : 48;
      p.nx = nudge(p.rx, span);
      p.ny = nudge(p.ry, span);
      if ($urandom_range(0, 3) == 0) begin
        p.rgx = 16'($signed(16'($urandom_range(0, 200))) - 100);
        p.rgy = 16'($signed(16'($urandom_range(0, 200))) - 100);
      end
      p.ngx = nudge(p.rgx, $urandom_range(0, 1) ? 300 : 8000);
      p.ngy = nudge(p.rgy, $urandom_range(0, 1) ? 300 : 8000);
    end
    return p;
  endfunction

  initial begin
    logic [15:0] dist_set[6]  = '{16'd32, 16'd0, 16'd65535, 16'd100, 16'd20, 16'd4000};
    logic [15:0] angle_set[6] = '{16'd2731, 16'd0, 16'd32768, 16'd65535, 16'd5000, 16'd300};

    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, zero vectors, half turn, both sides
    send('{16'd100, 16'd100, 16'd110, 16'd100, 16'sd100, 16'sd0, 16'sd100, 16'sd0, 1'b0});
    send('{16'd100, 16'd100, 16'd110, 16'd100, 16'sd100, 16'sd0, 16'sd100, 16'sd0, 1'b1});
    send('{16'd100, 16'd100, 16'd90, 16'd100, 16'sd100, 16'sd0, 16'sd100, 16'sd0, 1'b1});
    send('{16'd100, 16'd100, 16'd90, 16'd100, 16'sd100, 16'sd0, 16'sd100, 16'sd0, 1'b0});
    send('{16'd500, 16'd500, 16'd500, 16'd500, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0});
    send('{16'd500, 16'd500, 16'd500, 16'd500, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1});
    send('{16'd500, 16'd500, 16'd490, 16'd500, 16'sd50, 16'sd0, -16'sd50, 16'sd0, 1'b1});
    send('{16'd500, 16'd500, 16'd490, 16'd500, -16'sd50, 16'sd0, 16'sd50, 16'sd0, 1'b0});
    send('{16'd0, 16'd0, 16'd65535, 16'd65535, -16'sd32768, -16'sd32768,
           16'sd32767, 16'sd32767, 1'b0});
    send('{16'd65535, 16'd65535, 16'd0, 16'd0, 16'sd32767, -16'sd32768,
           -16'sd32768, 16'sd32767, 1'b1});
    send('{16'd65535, 16'd0, 16'd65520, 16'd10, 16'sd0, 16'sd1000, 16'sd0, 16'sd999, 1'b1});
    send('{16'd0, 16'd65535, 16'd5, 16'd65530, -16'sd1, 16'sd0, -16'sd1, -16'sd1, 1'b0});
    send('{16'd300, 16'd300, 16'd320, 16'd324, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 1'b0});
    send('{16'd300, 16'd300, 16'd300, 16'd332, 16'sd0, 16'sd32767, 16'sd5, 16'sd32767, 1'b1});
    drain();

    // one phase per threshold setting, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        write_reg(epct_pkg::REG_DIST, dist_set[ph]);
        write_reg(epct_pkg::REG_ANGLE, angle_set[ph]);
      end
      quiet = (ph == 2);
      for (int n = 0; n < 100; n++) begin
        send(random_pair());
        if (n == 50) drain();
      end
      drain();
    end

    $display("%0d pairs sent, %0d flags checked, %0d continuous, six threshold settings",
             board.beats_in, board.beats_out, board.passes);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
